>>> design/can_channel_mode_controller_unit_defines.svh
// assertion helpers for the channel mode controller checker
`ifndef CAN_CHANNEL_MODE_CONTROLLER_UNIT_DEFINES_SVH
`define CAN_CHANNEL_MODE_CONTROLLER_UNIT_DEFINES_SVH

// property must hold at every clock edge outside reset
`define CMC_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) prop) \
        else $error("cmc check failed");

// condition must never be seen outside reset
`define CMC_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) !(cond)) \
        else $error("cmc forbidden condition seen");

`endif

>>> design/can_cmc_pkg.sv
package can_cmc_pkg;

    // operation codes
    localparam logic [2:0] OP_SET_CTRL  = 3'd0;
    localparam logic [2:0] OP_SET_PDU   = 3'd1;
    localparam logic [2:0] OP_READ      = 3'd2;
    localparam logic [2:0] OP_TX_CHECK  = 3'd3;
    localparam logic [2:0] OP_TXC_CHECK = 3'd4;
    localparam logic [2:0] OP_RX_CHECK  = 3'd5;
    localparam logic [2:0] OP_BUSOFF    = 3'd6;

    // controller requests
    localparam logic [1:0] CREQ_NOP     = 2'd0;
    localparam logic [1:0] CREQ_STARTED = 2'd1;
    localparam logic [1:0] CREQ_STOPPED = 2'd2;
    localparam logic [1:0] CREQ_SLEEP   = 2'd3;

    // controller modes
    localparam logic [1:0] CM_STOPPED = 2'd0;
    localparam logic [1:0] CM_STARTED = 2'd1;
    localparam logic [1:0] CM_SLEEP   = 2'd2;

    // pdu modes
    localparam logic [2:0] PM_OFFLINE       = 3'd0;
    localparam logic [2:0] PM_RX_ONLINE     = 3'd1;
    localparam logic [2:0] PM_TX_ONLINE     = 3'd2;
    localparam logic [2:0] PM_ONLINE        = 3'd3;
    localparam logic [2:0] PM_OFF_ACTIVE    = 3'd4;
    localparam logic [2:0] PM_OFF_ACTIVE_RX = 3'd5;

    // pdu requests
    localparam logic [2:0] PREQ_OFFLINE     = 3'd0;
    localparam logic [2:0] PREQ_RX_OFF      = 3'd1;
    localparam logic [2:0] PREQ_RX_ON       = 3'd2;
    localparam logic [2:0] PREQ_TX_OFF      = 3'd3;
    localparam logic [2:0] PREQ_TX_ON       = 3'd4;
    localparam logic [2:0] PREQ_ONLINE      = 3'd5;
    localparam logic [2:0] PREQ_TX_OFF_ACTV = 3'd6;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    function automatic logic [2:0] pdu_next(input logic [2:0] cur, input logic [2:0] req);
        logic [2:0] nxt;
        nxt = cur;
        unique case (req)
            PREQ_OFFLINE: nxt = PM_OFFLINE;
            PREQ_RX_OFF:
            begin
                if (cur == PM_RX_ONLINE)          nxt = PM_OFFLINE;
                else if (cur == PM_ONLINE)        nxt = PM_TX_ONLINE;
                else if (cur == PM_OFF_ACTIVE_RX) nxt = PM_OFF_ACTIVE;
            end
            PREQ_RX_ON:
            begin
                if (cur == PM_OFFLINE)         nxt = PM_RX_ONLINE;
                else if (cur == PM_TX_ONLINE)  nxt = PM_ONLINE;
                else if (cur == PM_OFF_ACTIVE) nxt = PM_OFF_ACTIVE_RX;
            end
            PREQ_TX_OFF:
            begin
                if (cur == PM_TX_ONLINE || cur == PM_OFF_ACTIVE)
                    nxt = PM_OFFLINE;
                else if (cur == PM_ONLINE || cur == PM_OFF_ACTIVE_RX)
                    nxt = PM_RX_ONLINE;
            end
            PREQ_TX_ON:
            begin
                if (cur == PM_OFFLINE || cur == PM_OFF_ACTIVE)
                    nxt = PM_TX_ONLINE;
                else if (cur == PM_RX_ONLINE || cur == PM_OFF_ACTIVE_RX)
                    nxt = PM_ONLINE;
            end
            PREQ_ONLINE: nxt = PM_ONLINE;
            PREQ_TX_OFF_ACTV:
            begin
                if (cur == PM_OFFLINE || cur == PM_TX_ONLINE)
                    nxt = PM_OFF_ACTIVE;
                else if (cur == PM_RX_ONLINE || cur == PM_ONLINE)
                    nxt = PM_OFF_ACTIVE_RX;
            end
            default: nxt = cur;
        endcase
        return nxt;
    endfunction

endpackage

>>> design/can_cmc_ctrl.sv
module can_cmc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output can_cmc_pkg::cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> design/can_cmc_datapath.sv
module can_cmc_datapath #(
    parameter int CHANNEL_COUNT = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  can_cmc_pkg::cmd_t  cmd,
    input  logic [2:0]         operation,
    input  logic [7:0]         channel,
    input  logic [1:0]         controller_request,
    input  logic [2:0]         pdu_request,
    output logic               done,
    output logic               accepted,
    output logic               allowed,
    output logic [1:0]         controller_mode,
    output logic [2:0]         pdu_mode,
    output logic               error_code
);

    localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // one word per channel: controller mode above pdu mode
    logic [4:0]       mode_mem_reg [CHANNEL_COUNT];
    logic             valid_reg [CHANNEL_COUNT];

    logic [2:0]       op_reg;
    logic [1:0]       creq_reg;
    logic [2:0]       preq_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             ch_ok_reg;
    logic [4:0]       rd_data_reg;
    logic             rd_valid_reg;

    logic             done_reg;
    logic             accepted_reg;
    logic             allowed_reg;
    logic [1:0]       cm_reg;
    logic [2:0]       pm_reg;
    logic             err_reg;

    logic [IDX_W-1:0] rd_idx;
    logic             ch_ok;
    logic [1:0]       cur_cm;
    logic [2:0]       cur_pm;
    logic [1:0]       cm_next;
    logic [2:0]       pm_next;
    logic             accepted_next;
    logic             allowed_next;

    assign rd_idx = channel[IDX_W-1:0];
    assign ch_ok  = ({1'b0, channel} < 9'(CHANNEL_COUNT));

    // never-written entries read as stopped / offline
    assign cur_cm = rd_valid_reg ? rd_data_reg[4:3] : can_cmc_pkg::CM_STOPPED;
    assign cur_pm = rd_valid_reg ? rd_data_reg[2:0] : can_cmc_pkg::PM_OFFLINE;

    always_comb
    begin
        cm_next       = cur_cm;
        pm_next       = cur_pm;
        accepted_next = 1'b0;
        allowed_next  = 1'b0;
        case (op_reg)
            can_cmc_pkg::OP_SET_CTRL:
            begin
                accepted_next = 1'b1;
                case (creq_reg)
                    can_cmc_pkg::CREQ_STARTED:
                    begin
                        cm_next = can_cmc_pkg::CM_STARTED;
                        pm_next = can_cmc_pkg::PM_ONLINE;
                    end
                    can_cmc_pkg::CREQ_STOPPED:
                    begin
                        cm_next = can_cmc_pkg::CM_STOPPED;
                        pm_next = can_cmc_pkg::PM_OFFLINE;
                    end
                    can_cmc_pkg::CREQ_SLEEP: cm_next = can_cmc_pkg::CM_SLEEP;
                    default: cm_next = cur_cm;
                endcase
            end
            can_cmc_pkg::OP_SET_PDU:
            begin
                if (preq_reg <= can_cmc_pkg::PREQ_TX_OFF_ACTV)
                begin
                    accepted_next = 1'b1;
                    pm_next       = can_cmc_pkg::pdu_next(cur_pm, preq_reg);
                end
            end
            can_cmc_pkg::OP_READ: accepted_next = 1'b1;
            can_cmc_pkg::OP_TX_CHECK:
            begin
                allowed_next  = (cur_cm == can_cmc_pkg::CM_STARTED) &&
                                (cur_pm == can_cmc_pkg::PM_TX_ONLINE ||
                                 cur_pm == can_cmc_pkg::PM_ONLINE);
                accepted_next = allowed_next;
            end
            can_cmc_pkg::OP_TXC_CHECK:
            begin
                accepted_next = 1'b1;
                allowed_next  = (cur_pm == can_cmc_pkg::PM_TX_ONLINE ||
                                 cur_pm == can_cmc_pkg::PM_ONLINE ||
                                 cur_pm == can_cmc_pkg::PM_OFF_ACTIVE ||
                                 cur_pm == can_cmc_pkg::PM_OFF_ACTIVE_RX);
            end
            can_cmc_pkg::OP_RX_CHECK:
            begin
                accepted_next = 1'b1;
                allowed_next  = (cur_pm == can_cmc_pkg::PM_RX_ONLINE ||
                                 cur_pm == can_cmc_pkg::PM_ONLINE ||
                                 cur_pm == can_cmc_pkg::PM_OFF_ACTIVE_RX);
            end
            can_cmc_pkg::OP_BUSOFF:
            begin
                accepted_next = 1'b1;
                cm_next       = can_cmc_pkg::CM_STOPPED;
                pm_next       = can_cmc_pkg::PM_OFFLINE;
            end
            default: accepted_next = 1'b0;
        endcase
    end

    // request capture and store read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            creq_reg    <= controller_request;
            preq_reg    <= pdu_request;
            idx_reg     <= rd_idx;
            rd_data_reg <= mode_mem_reg[rd_idx];
        end
        if (cmd.exec && ch_ok_reg)
            mode_mem_reg[idx_reg] <= {cm_next, pm_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_ok_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ch_ok_reg    <= ch_ok;
                rd_valid_reg <= ch_ok && valid_reg[rd_idx];
            end
            if (cmd.exec && ch_ok_reg)
                valid_reg[idx_reg] <= 1'b1;
        end
    end

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.exec;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (ch_ok_reg)
            begin
                accepted_reg <= accepted_next;
                allowed_reg  <= allowed_next;
                cm_reg       <= cm_next;
                pm_reg       <= pm_next;
                err_reg      <= 1'b0;
            end
            else
            begin
                accepted_reg <= 1'b0;
                allowed_reg  <= 1'b0;
                cm_reg       <= can_cmc_pkg::CM_STOPPED;
                pm_reg       <= can_cmc_pkg::PM_OFFLINE;
                err_reg      <= 1'b1;
            end
        end
    end

    assign done            = done_reg;
    assign accepted        = accepted_reg;
    assign allowed         = allowed_reg;
    assign controller_mode = cm_reg;
    assign pdu_mode        = pm_reg;
    assign error_code      = err_reg;

endmodule

>>> design/can_channel_mode_controller_unit.sv
// can channel mode controller: per-channel controller mode and pdu mode
// request channel: operation, channel, controller_request, pdu_request are
//   taken as one beat at a rising edge with start high and busy low
// result channel: accepted, allowed, controller_mode, pdu_mode, error_code
//   are shown for exactly one cycle while done is high; the receiver cannot
//   stall, so a result beat is never held back or repeated
// sequence: a request beat taken on the accepting edge is executed on the
//   executing edge, and its result is shown in the cycle after; no new
//   request is taken until it has executed, as the mode store is read on
//   the accepting edge and written back on the executing edge
// busy is high in the single execute cycle; a new request may arrive in the
//   same cycle that the previous result is shown
// a channel number at or above CHANNEL_COUNT returns error_code 1 and
//   changes nothing
// reset: all channels read back stopped and offline at once (per-channel
//   valid bits), no clearing pass is needed
module can_channel_mode_controller_unit #(
    parameter int CHANNEL_COUNT = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] operation,
    input  logic [7:0] channel,
    input  logic [1:0] controller_request,
    input  logic [2:0] pdu_request,
    output logic       done,
    output logic       accepted,
    output logic       allowed,
    output logic [1:0] controller_mode,
    output logic [2:0] pdu_mode,
    output logic       error_code
);

    // load / execute commands from the sequencer
    can_cmc_pkg::cmd_t cmd;

    can_cmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // mode store, transition logic and result registers
    can_cmc_datapath #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .operation          (operation),
        .channel            (channel),
        .controller_request (controller_request),
        .pdu_request        (pdu_request),
        .done               (done),
        .accepted           (accepted),
        .allowed            (allowed),
        .controller_mode    (controller_mode),
        .pdu_mode           (pdu_mode),
        .error_code         (error_code)
    );

endmodule

>>> design/can_cmc_checker.sv
`include "can_channel_mode_controller_unit_defines.svh"

module can_cmc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       accepted,
    input logic       allowed,
    input logic [1:0] controller_mode,
    input logic [2:0] pdu_mode,
    input logic       error_code
);

    // every accepted request gives its result beat once its execute cycle is over
    `CMC_ASSERT(a_result_follows, clk, rst_n, (start && !busy) |=> ##1 done)
    // busy covers the execute cycle of an accepted request
    `CMC_ASSERT(a_busy_after_accept, clk, rst_n, (start && !busy) |=> busy)
    // a result beat is never shown while executing
    `CMC_NEVER(a_done_not_busy, clk, rst_n, done && busy)
    // out-of-range channel reports nothing else
    `CMC_ASSERT(a_range_error, clk, rst_n,
        (done && error_code) |-> (!accepted && !allowed &&
            controller_mode == can_cmc_pkg::CM_STOPPED &&
            pdu_mode == can_cmc_pkg::PM_OFFLINE))
    // a passing gate is always an accepted request
    `CMC_ASSERT(a_allowed_accepted, clk, rst_n, (done && allowed) |-> accepted)

endmodule

bind can_channel_mode_controller_unit can_cmc_checker u_can_cmc_checker (.*);
